// File: hw/rtl/sipq_pkg.sv
`default_nettype none

package sipq_pkg;

  localparam int unsigned DefCapacity = 8;

  localparam int unsigned ActionW = 2;
  localparam int unsigned KeyW    = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 4;

  localparam logic [ActionW-1:0] ACT_INSERT = 2'd0;
  localparam logic [ActionW-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ActionW-1:0] ACT_PEEK   = 2'd2;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic                 load;
    logic                 do_ins;
    logic                 do_rem;
    logic                 give_head;
    logic [StatusW-1:0]   status;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/sipq_ctrl.sv
`default_nettype none

module sipq_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [sipq_pkg::ActionW-1:0]  action_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  input  wire sipq_pkg::dp_stat_t            stat_i,
  output sipq_pkg::dp_cmd_t                  cmd_o
);
  import sipq_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign accept      = in_valid_i && in_ready_o;

  // Decode the operation against the current fill state
  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = accept;
    cmd_o.status    = ST_OK;
    case (action_i)
      ACT_INSERT: begin
        if (stat_i.full) begin
          cmd_o.status = ST_FULL;
        end else begin
          cmd_o.do_ins = accept;
        end
      end
      ACT_REMOVE, ACT_PEEK: begin
        if (stat_i.empty) begin
          cmd_o.status = ST_EMPTY;
        end else begin
          cmd_o.give_head = 1'b1;
          cmd_o.do_rem    = accept && (action_i == ACT_REMOVE);
        end
      end
      default: begin
        cmd_o.status = ST_OK;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_OUT;
      ST_OUT:  if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sipq_dp.sv
`default_nettype none

module sipq_dp #(
  parameter int unsigned Capacity = sipq_pkg::DefCapacity
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [sipq_pkg::KeyW-1:0]     key_in_i,
  input  wire sipq_pkg::dp_cmd_t             cmd_i,
  output sipq_pkg::dp_stat_t                 stat_o,
  output logic [sipq_pkg::KeyW-1:0]          key_out_o,
  output logic [sipq_pkg::StatusW-1:0]       status_o,
  output logic [sipq_pkg::OccW-1:0]          occupancy_o
);
  import sipq_pkg::*;

  localparam int unsigned CntW = $clog2(Capacity + 1);

  logic [KeyW-1:0]    slots_q [Capacity];
  logic [KeyW-1:0]    ins_val [Capacity];
  logic [Capacity-1:0] lt;
  logic [CntW-1:0]    count_q, count_d;
  logic [KeyW-1:0]    key_out_q;
  logic [StatusW-1:0] status_q;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(Capacity));

  // Every cell compares against the new key at once; the list stays sorted,
  // so cells below the insert point are exactly those holding a smaller key.
  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      lt[i] = (CntW'(i) < count_q) && (slots_q[i] < key_in_i);
    end
    ins_val[0] = lt[0] ? slots_q[0] : key_in_i;
    for (int i = 1; i < Capacity; i++) begin
      if (lt[i]) begin
        ins_val[i] = slots_q[i];
      end else if (lt[i-1]) begin
        ins_val[i] = key_in_i;
      end else begin
        ins_val[i] = slots_q[i-1];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.do_ins) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.do_rem) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_ins) begin
      for (int i = 0; i < Capacity; i++) begin
        slots_q[i] <= ins_val[i];
      end
    end else if (cmd_i.do_rem) begin
      // advance every key one cell toward the head
      for (int i = 0; i + 1 < Capacity; i++) begin
        slots_q[i] <= slots_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_out_q <= cmd_i.give_head ? slots_q[0] : '0;
      status_q  <= cmd_i.status;
    end
  end

  assign key_out_o   = key_out_q;
  assign status_o    = status_q;
  assign occupancy_o = OccW'(count_q);

endmodule

`default_nettype wire

// File: hw/rtl/sorted_insertion_priority_queue_core.sv
// Sorted insertion priority queue of unsigned byte keys.
//
// Input channel (in_valid_i / in_ready_o) carries one beat per operation:
// action_i selects insert, remove smallest or peek smallest; key_in_i is
// the key for an insert. Output channel (out_valid_o / out_ready_i) returns
// exactly one beat per input beat: key_out_o, status_o and occupancy_o
// (keys held after the operation, low four bits).
//
// Each beat executes in the accept cycle over a row of Capacity
// compare-and-shift cells, and the result is offered from the following
// cycle. The next input beat is accepted in the cycle after the result is
// taken.
//
// A stalled receiver holds the result and the queue; no input is taken
// until the result beat completes.
// Reset empties the queue at once; no clearing pass is needed, as cells
// beyond the fill count are never read.
`default_nettype none

module sorted_insertion_priority_queue_core #(
  parameter int unsigned Capacity = sipq_pkg::DefCapacity
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [sipq_pkg::ActionW-1:0]  action_i,
  input  wire logic [sipq_pkg::KeyW-1:0]     key_in_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [sipq_pkg::KeyW-1:0]          key_out_o,
  output logic [sipq_pkg::StatusW-1:0]       status_o,
  output logic [sipq_pkg::OccW-1:0]          occupancy_o
);
  import sipq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sipq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sipq_dp #(
    .Capacity (Capacity)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_in_i    (key_in_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .key_out_o   (key_out_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/sipq_checker.sv
`default_nettype none

module sipq_checker #(
  parameter int unsigned Capacity = sipq_pkg::DefCapacity
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [sipq_pkg::KeyW-1:0]     key_out_o,
  input wire logic [sipq_pkg::StatusW-1:0]  status_o,
  input wire logic [sipq_pkg::OccW-1:0]     occupancy_o
);
  import sipq_pkg::*;

  // A held result beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(key_out_o)
      && $stable(status_o) && $stable(occupancy_o))
  else $error("stalled result beat changed");

  // Every accepted operation offers its result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
  else $error("result not offered after accept");

  // No new operation while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
  else $error("input taken while result pending");

  // Empty report means nothing held and no key given
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> occupancy_o == '0 && key_out_o == '0)
  else $error("empty report inconsistent");

  // Full report only at capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> occupancy_o == OccW'(Capacity)
      && key_out_o == '0)
  else $error("full report inconsistent");

endmodule

bind sorted_insertion_priority_queue_core sipq_checker #(
  .Capacity (Capacity)
) u_sipq_checker (.*);

`default_nettype wire
